### src/brnpc_pkg.sv
// ----------------------------------------------------------------------------
// brnpc_pkg: shared types and constants for the branch next-pc unit
// Opcode match patterns, branch class codes, register file sizing and the
// bit layout of the stream words.
// ----------------------------------------------------------------------------
package brnpc_pkg;

    // Shadow register file sizing
    localparam int REG_COUNT  = 16;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int XLEN       = 32;
    localparam int OP_W       = 16;

    // Register returned by RTE
    localparam logic [REG_IDX_W-1:0] RTE_REG = REG_IDX_W'(REG_COUNT - 1);

    // Input word layout, lowest field first
    localparam int IN_IDX_LSB  = 0;
    localparam int IN_VAL_LSB  = IN_IDX_LSB + REG_IDX_W;
    localparam int IN_OP_LSB   = IN_VAL_LSB + XLEN;
    localparam int IN_PC_LSB   = IN_OP_LSB + OP_W;
    localparam int IN_T_LSB    = IN_PC_LSB + XLEN;
    localparam int IN_RA_LSB   = IN_T_LSB + 1;
    localparam int IN_BITS     = IN_RA_LSB + XLEN;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Output word layout, lowest field first
    localparam int OUT_CLS_W   = 4;
    localparam int OUT_CLS_LSB = XLEN;
    localparam int OUT_TK_LSB  = OUT_CLS_LSB + OUT_CLS_W;
    localparam int OUT_BITS    = OUT_TK_LSB + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Item kinds carried in tuser
    typedef enum logic {
        KIND_WRITE   = 1'b0,
        KIND_COMPUTE = 1'b1
    } item_kind_t;

    // Branch classes reported with each result
    typedef enum logic [OUT_CLS_W-1:0] {
        CLS_OTHER = 4'd0,
        CLS_BT    = 4'd1,
        CLS_BTS   = 4'd2,
        CLS_BF    = 4'd3,
        CLS_BFS   = 4'd4,
        CLS_BRA   = 4'd5,
        CLS_BRAF  = 4'd6,
        CLS_BSR   = 4'd7,
        CLS_BSRF  = 4'd8,
        CLS_JMP   = 4'd9,
        CLS_JSR   = 4'd10,
        CLS_RTS   = 4'd11,
        CLS_RTE   = 4'd12
    } branch_class_t;

    // Opcode masks and match patterns
    localparam logic [OP_W-1:0] MASK_HI8   = 16'hff00;
    localparam logic [OP_W-1:0] MASK_HI4   = 16'hf000;
    localparam logic [OP_W-1:0] MASK_REG   = 16'hf0ff;
    localparam logic [OP_W-1:0] PAT_BT     = 16'h8900;
    localparam logic [OP_W-1:0] PAT_BTS    = 16'h8d00;
    localparam logic [OP_W-1:0] PAT_BF     = 16'h8b00;
    localparam logic [OP_W-1:0] PAT_BFS    = 16'h8f00;
    localparam logic [OP_W-1:0] PAT_BRA    = 16'ha000;
    localparam logic [OP_W-1:0] PAT_BRAF   = 16'h0023;
    localparam logic [OP_W-1:0] PAT_BSR    = 16'hb000;
    localparam logic [OP_W-1:0] PAT_BSRF   = 16'h0003;
    localparam logic [OP_W-1:0] PAT_JMP    = 16'h402b;
    localparam logic [OP_W-1:0] PAT_JSR    = 16'h400b;
    localparam logic [OP_W-1:0] PAT_RTS    = 16'h000b;
    localparam logic [OP_W-1:0] PAT_RTE    = 16'h002b;

    // One result word
    typedef struct packed {
        logic          taken;
        branch_class_t branch_class;
        logic [XLEN-1:0] next_pc;
    } npc_result_t;

endpackage

### src/brnpc_regfile.sv
// ----------------------------------------------------------------------------
// brnpc_regfile: shadow general register file
// One write port, one indexed read port and a fixed read of the RTE register.
// All entries clear on reset.
// ----------------------------------------------------------------------------
module brnpc_regfile
    import brnpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_idx,
    input  logic [XLEN-1:0]      wr_data,
    input  logic [REG_IDX_W-1:0] rd_idx,
    output logic [XLEN-1:0]      rd_data,
    output logic [XLEN-1:0]      rte_data
);

    logic [XLEN-1:0] regs_reg [REG_COUNT];

    // Write one entry, clear all on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                regs_reg[i] <= '0;
            end
        end else if (wr_en) begin
            regs_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data  = regs_reg[rd_idx];
    assign rte_data = regs_reg[RTE_REG];

endmodule

### src/brnpc_decode.sv
// ----------------------------------------------------------------------------
// brnpc_decode: opcode decode and target adder
// Classifies the opcode, picks the offset from pc+4 and selects the target.
// ----------------------------------------------------------------------------
module brnpc_decode
    import brnpc_pkg::*;
(
    input  logic [OP_W-1:0] opcode,
    input  logic [XLEN-1:0] pc,
    input  logic            t_flag,
    input  logic [XLEN-1:0] return_addr,
    input  logic [XLEN-1:0] rn_data,
    input  logic [XLEN-1:0] rte_data,
    output npc_result_t     result
);

    // Offsets are relative to pc+4
    localparam logic [XLEN-1:0] OFF_SEQ  = -XLEN'(2);
    localparam logic [XLEN-1:0] OFF_SKIP = '0;

    logic [XLEN-1:0] disp8;
    logic [XLEN-1:0] disp12;
    logic [XLEN-1:0] offset;
    logic [XLEN-1:0] rel_target;
    logic [1:0]      tsel;
    branch_class_t   cls_sel;
    logic            taken_sel;
    logic [XLEN-1:0] next_pc_sel;

    localparam logic [1:0] TSEL_REL = 2'd0;
    localparam logic [1:0] TSEL_RN  = 2'd1;
    localparam logic [1:0] TSEL_RA  = 2'd2;
    localparam logic [1:0] TSEL_RTE = 2'd3;

    // Sign-extended halfword displacements
    assign disp8  = {{(XLEN-9){opcode[7]}}, opcode[7:0], 1'b0};
    assign disp12 = {{(XLEN-13){opcode[11]}}, opcode[11:0], 1'b0};

    // Classify, first match wins
    always_comb begin
        cls_sel   = CLS_OTHER;
        taken_sel = 1'b0;
        offset    = OFF_SEQ;
        tsel      = TSEL_REL;
        if ((opcode & MASK_HI8) == PAT_BT) begin
            cls_sel   = CLS_BT;
            taken_sel = t_flag;
            offset    = t_flag ? disp8 : OFF_SEQ;
        end else if ((opcode & MASK_HI8) == PAT_BTS) begin
            cls_sel   = CLS_BTS;
            taken_sel = t_flag;
            offset    = t_flag ? disp8 : OFF_SKIP;
        end else if ((opcode & MASK_HI8) == PAT_BF) begin
            cls_sel   = CLS_BF;
            taken_sel = !t_flag;
            offset    = t_flag ? OFF_SEQ : disp8;
        end else if ((opcode & MASK_HI8) == PAT_BFS) begin
            cls_sel   = CLS_BFS;
            taken_sel = !t_flag;
            offset    = t_flag ? OFF_SKIP : disp8;
        end else if ((opcode & MASK_HI4) == PAT_BRA) begin
            cls_sel   = CLS_BRA;
            taken_sel = 1'b1;
            offset    = disp12;
        end else if ((opcode & MASK_REG) == PAT_BRAF) begin
            cls_sel   = CLS_BRAF;
            taken_sel = 1'b1;
            offset    = rn_data;
        end else if ((opcode & MASK_HI4) == PAT_BSR) begin
            cls_sel   = CLS_BSR;
            taken_sel = 1'b1;
            offset    = disp12;
        end else if ((opcode & MASK_REG) == PAT_BSRF) begin
            cls_sel   = CLS_BSRF;
            taken_sel = 1'b1;
            offset    = rn_data;
        end else if ((opcode & MASK_REG) == PAT_JMP) begin
            cls_sel   = CLS_JMP;
            taken_sel = 1'b1;
            tsel      = TSEL_RN;
        end else if ((opcode & MASK_REG) == PAT_JSR) begin
            cls_sel   = CLS_JSR;
            taken_sel = 1'b1;
            tsel      = TSEL_RN;
        end else if (opcode == PAT_RTS) begin
            cls_sel   = CLS_RTS;
            taken_sel = 1'b1;
            tsel      = TSEL_RA;
        end else if (opcode == PAT_RTE) begin
            cls_sel   = CLS_RTE;
            taken_sel = 1'b1;
            tsel      = TSEL_RTE;
        end
    end

    // pc-relative target, wraps modulo 2^32
    assign rel_target = pc + XLEN'(4) + offset;

    // Select the final target
    always_comb begin
        case (tsel)
            TSEL_RN:  next_pc_sel = rn_data;
            TSEL_RA:  next_pc_sel = return_addr;
            TSEL_RTE: next_pc_sel = rte_data;
            default:  next_pc_sel = rel_target;
        endcase
    end

    // Pack the result word
    assign result = {taken_sel, cls_sel, next_pc_sel};

endmodule

### src/branch_next_pc_calc_unit.sv
// ----------------------------------------------------------------------------
// branch_next_pc_calc_unit: next instruction address for a 16-bit opcode
// A compute word passes through the input register, then the output register.
// Throughput: one word per cycle from the single decode/add stage unless the output stalls.
// Write words update the shadow registers and produce no result.
// Reset clears both stage valids and all shadow registers at once.
// ----------------------------------------------------------------------------
module branch_next_pc_calc_unit
    import brnpc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: reg_index, reg_value, opcode, pc, t_flag, return_addr, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: next_pc, branch_class, taken, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                  s1_valid_reg;
    logic                  s1_kind_reg;
    logic [IN_BITS-1:0]    s1_data_reg;
    logic                  s1_move;
    logic                  out_free;
    logic                  m_valid_reg;
    npc_result_t           m_res_reg;
    npc_result_t           dec_res;
    logic [XLEN-1:0]       rn_data;
    logic [XLEN-1:0]       rte_data;
    logic [OP_W-1:0]       s1_opcode;
    logic                  s1_is_write;

    assign s1_opcode   = s1_data_reg[IN_OP_LSB +: OP_W];
    assign s1_is_write = (s1_kind_reg == KIND_WRITE);

    // Handshake: writes always drain, computes need room at the output
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && (s1_is_write || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_move;

    // Hold the accepted word in the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            s1_kind_reg <= s_axis_tuser;
            s1_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    // Shadow registers, written as a write word leaves the input register
    brnpc_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s1_move && s1_is_write),
        .wr_idx   (s1_data_reg[IN_IDX_LSB +: REG_IDX_W]),
        .wr_data  (s1_data_reg[IN_VAL_LSB +: XLEN]),
        .rd_idx   (s1_opcode[11:8]),
        .rd_data  (rn_data),
        .rte_data (rte_data)
    );

    brnpc_decode u_decode (
        .opcode      (s1_opcode),
        .pc          (s1_data_reg[IN_PC_LSB +: XLEN]),
        .t_flag      (s1_data_reg[IN_T_LSB]),
        .return_addr (s1_data_reg[IN_RA_LSB +: XLEN]),
        .rn_data     (rn_data),
        .rte_data    (rte_data),
        .result      (dec_res)
    );

    // Advance a compute result into the output register, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg && !s1_is_write;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg && !s1_is_write) begin
            m_res_reg <= dec_res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, m_res_reg};

endmodule
